// ----- design/blocking_average_error_macros.svh -----
// Assertion macros shared by the blocking average error design.
`ifndef BLOCKING_AVERAGE_ERROR_MACROS_SVH
`define BLOCKING_AVERAGE_ERROR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BAE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blocking average error: property failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BAE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blocking average error: property failed");

`endif

// ----- design/bae_pkg.sv -----
// Types, constants and helper functions of the blocking average error design.
`default_nettype none

package bae_pkg;

   localparam int Q16_BITS = 16;
   localparam logic [Q16_BITS-1:0] Q16_HALF = 16'h8000;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam int DIV_NUM_BITS = 64;
   localparam int DIV_DEN_BITS = 48;
   localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS + 1);

   localparam int SQRT_RAD_BITS = 64;
   localparam int SQRT_ROOT_BITS = SQRT_RAD_BITS / 2;
   localparam int SQRT_REM_BITS = SQRT_ROOT_BITS + 2;
   localparam int SQRT_CNT_BITS = $clog2(SQRT_ROOT_BITS + 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BLOCK_LENGTH = 2'd0,
      CSR_BLOCK_COUNT  = 2'd1,
      CSR_MODE         = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ACC,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_UPD,
      S_MSQ,
      S_RMEAN_GO,
      S_RMEAN_WAIT,
      S_A_LO,
      S_A_HI,
      S_B,
      S_DIFF,
      S_DEN,
      S_Q_GO,
      S_Q_WAIT,
      S_ROOT_GO,
      S_ROOT_WAIT,
      S_OUT
   } bae_state_type;

   // Status of an iterative arithmetic unit; done pulses for one cycle.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic [Q16_BITS-1:0] sat16(input logic [DIV_NUM_BITS-1:0] value);
      logic [Q16_BITS-1:0] result;
      begin
         if (|value[DIV_NUM_BITS-1:Q16_BITS]) begin
            result = '1;
         end else begin
            result = value[Q16_BITS-1:0];
         end
         return result;
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/bae_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module bae_div
   import bae_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [DIV_NUM_BITS-1:0] num,
   input  wire logic [DIV_DEN_BITS-1:0] den,
   output logic      [DIV_NUM_BITS-1:0] quot,
   output unit_status_type              status
);

   logic [DIV_NUM_BITS-1:0] quot_ff, quot_in;
   logic [DIV_DEN_BITS-1:0] rem_ff, rem_in;
   logic [DIV_DEN_BITS-1:0] den_ff, den_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic                    done_ff, done_in;
   logic [DIV_DEN_BITS:0]   rem_shift;
   logic [DIV_DEN_BITS:0]   rem_diff;
   logic                    take;

   assign rem_shift = {rem_ff, quot_ff[DIV_NUM_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign take      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = num;
         rem_in   = '0;
         den_in   = den;
         count_in = DIV_CNT_BITS'(DIV_NUM_BITS);
      end else if (count_ff != '0) begin
         quot_in  = {quot_ff[DIV_NUM_BITS-2:0], take};
         rem_in   = take ? rem_diff[DIV_DEN_BITS-1:0] : rem_shift[DIV_DEN_BITS-1:0];
         count_in = count_ff - DIV_CNT_BITS'(1);
         done_in  = (count_ff == DIV_CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign quot        = quot_ff;
   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ----- design/bae_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module bae_sqrt
   import bae_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [SQRT_RAD_BITS-1:0]  rad,
   output logic      [SQRT_ROOT_BITS-1:0] root,
   output unit_status_type                status
);

   logic [SQRT_RAD_BITS-1:0]   rad_ff, rad_in;
   logic [SQRT_ROOT_BITS-1:0]  root_ff, root_in;
   logic [SQRT_REM_BITS-1:0]   rem_ff, rem_in;
   logic [SQRT_CNT_BITS-1:0]   count_ff, count_in;
   logic                       done_ff, done_in;
   logic [SQRT_REM_BITS+1:0]   rem_shift;
   logic [SQRT_REM_BITS+1:0]   trial;
   logic [SQRT_REM_BITS+1:0]   rem_diff;
   logic                       take;

   assign rem_shift = {rem_ff, rad_ff[SQRT_RAD_BITS-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign rem_diff  = rem_shift - trial;
   assign take      = rem_shift >= trial;

   always_comb begin
      rad_in   = rad_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rad_in   = rad;
         root_in  = '0;
         rem_in   = '0;
         count_in = SQRT_CNT_BITS'(SQRT_ROOT_BITS);
      end else if (count_ff != '0) begin
         rad_in   = {rad_ff[SQRT_RAD_BITS-3:0], 2'b00};
         root_in  = {root_ff[SQRT_ROOT_BITS-2:0], take};
         rem_in   = take ? rem_diff[SQRT_REM_BITS-1:0] : rem_shift[SQRT_REM_BITS-1:0];
         count_in = count_ff - SQRT_CNT_BITS'(1);
         done_in  = (count_ff == SQRT_CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign root        = root_ff;
   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ----- design/blocking_average_error.sv -----
// Top level of the blocking (batch means) average and standard error estimator.
//
//   Channel   Ports                                       Direction  Handshake
//   request   req_valid, req_stall, req_sample            in         valid / stall
//   response  rsp_valid, rsp_stall, rsp_* results         out        valid / stall
//   csr       csr_valid, csr_ready, csr_index, csr_data   in         valid / ready
//
// Samples that do not close a block stream in at one request per cycle; a request
// is held in the sample register and added to the block sum in the cycle after.
// A request that closes a block stalls requests until the closing sequence has
// run (a shorter one for the first block, which has no error term). Its length
// is set by the shared divider, which produces one quotient bit per cycle over up
// to three 64-bit divisions, and by the 32-step square root. A result still held
// in the output register lengthens the stall.
// Reset restores block length 100, block count 100 and mode 0 and clears all sums.
// A finished result waits in the output register while new requests are taken.
`default_nettype none
`include "blocking_average_error_macros.svh"

module blocking_average_error
   import bae_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [SAMPLE_BITS-1:0]    req_sample,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [31:0]                    rsp_samples_done,
   output logic [Q16_BITS-1:0]            rsp_running_mean,
   output logic [Q16_BITS-1:0]            rsp_std_error,
   output logic [15:0]                    rsp_block_number,
   output logic                           rsp_last_block,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   // Configuration registers.
   logic [15:0] block_length_ff, block_length_in;
   logic [15:0] block_count_ff, block_count_in;
   logic        mode_ff, mode_in;

   // Running state of the estimator.
   bae_state_type state_ff, state_in;
   logic [31:0]  block_sum_ff, block_sum_in;
   logic [15:0]  block_fill_ff, block_fill_in;
   logic [15:0]  blocks_done_ff, blocks_done_in;
   logic [31:0]  mean_sum_ff, mean_sum_in;
   logic [47:0]  mss_ff, mss_in;

   // Working registers of the closing sequence.
   logic [Q16_BITS-1:0] sample_ff, sample_in;
   logic [Q16_BITS-1:0] mean_ff, mean_in;
   logic [Q16_BITS-1:0] rmean_ff, rmean_in;
   logic [Q16_BITS-1:0] err_ff, err_in;
   logic [31:0]         sdone_ff, sdone_in;
   logic [63:0]         acc_ff, acc_in;
   logic [63:0]         diff_ff, diff_in;
   logic [63:0]         prod_ff, prod_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_samples_done_ff;
   logic [Q16_BITS-1:0] rsp_running_mean_ff;
   logic [Q16_BITS-1:0] rsp_std_error_ff;
   logic [15:0]         rsp_block_number_ff;
   logic                rsp_last_block_ff;

   logic [Q16_BITS-1:0] req_q16;
   logic                req_fire;
   logic                csr_fire;
   logic                rsp_load;
   logic [15:0]         len;
   logic                run_over;
   logic [15:0]         fill_inc;
   logic                closes;
   logic [Q16_BITS-1:0] abs_dev;
   logic [Q16_BITS-1:0] term;
   logic [32:0]         mean_num;
   logic [32:0]         rmean_num;
   logic [64:0]         sub_ab;

   // Shared multiplier and its operand selection.
   logic [31:0] mult_a;
   logic [31:0] mult_b;
   logic [63:0] mult_p;

   // Shared divider and square root.
   logic                      div_start;
   logic [DIV_NUM_BITS-1:0]   div_num;
   logic [DIV_DEN_BITS-1:0]   div_den;
   logic [DIV_NUM_BITS-1:0]   div_quot;
   unit_status_type           div_status;
   logic                      sqrt_start;
   logic [SQRT_ROOT_BITS-1:0] sqrt_root;
   unit_status_type           sqrt_status;

   // Bring the sample to Q0.16 by dropping low bits or appending zeros.
   generate
      if (SAMPLE_BITS >= Q16_BITS) begin : g_trunc
         assign req_q16 = req_sample[SAMPLE_BITS-1 -: Q16_BITS];
      end else begin : g_extend
         assign req_q16 = {req_sample, {(Q16_BITS-SAMPLE_BITS){1'b0}}};
      end
   endgenerate

   // A block length of zero behaves as one.
   assign len      = (block_length_ff == '0) ? 16'd1 : block_length_ff;
   assign run_over = (blocks_done_ff >= block_count_ff);
   assign fill_inc = block_fill_ff + 16'd1;
   // The block also closes when the fill count wraps around to zero.
   assign closes   = (fill_inc >= len) || (fill_inc == '0);

   assign abs_dev  = (sample_ff >= Q16_HALF) ? (sample_ff - Q16_HALF) : (Q16_HALF - sample_ff);
   assign mult_p   = {32'b0, mult_a} * {32'b0, mult_b};
   assign term     = mode_ff ? mult_p[2*Q16_BITS-1:Q16_BITS] : sample_ff;

   // Rounded-half-up numerators of the two mean divisions.
   assign mean_num  = {1'b0, block_sum_ff} + {18'b0, len[15:1]};
   assign rmean_num = {1'b0, mean_sum_ff} + {18'b0, blocks_done_ff[15:1]};
   assign sub_ab    = {1'b0, acc_ff} - {1'b0, prod_ff};

   // A request is taken when idle, or while accumulating if the held sample will
   // not close a block (or is ignored because all blocks are done).
   assign req_stall = !((state_ff == S_IDLE) ||
                        ((state_ff == S_ACC) && (run_over || !closes)));
   assign req_fire  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_ACC;
         end
         S_ACC: begin
            if (!run_over && closes) begin
               state_in = S_MEAN_GO;
            end else if (!req_fire) begin
               state_in = S_IDLE;
            end
         end
         S_MEAN_GO:   state_in = S_MEAN_WAIT;
         S_MEAN_WAIT: begin
            if (div_status.done) state_in = S_UPD;
         end
         S_UPD:       state_in = S_MSQ;
         S_MSQ:       state_in = S_RMEAN_GO;
         S_RMEAN_GO:  state_in = S_RMEAN_WAIT;
         S_RMEAN_WAIT: begin
            if (div_status.done) begin
               state_in = (blocks_done_ff == 16'd1) ? S_OUT : S_A_LO;
            end
         end
         S_A_LO:      state_in = S_A_HI;
         S_A_HI:      state_in = S_B;
         S_B:         state_in = S_DIFF;
         S_DIFF:      state_in = S_DEN;
         S_DEN:       state_in = S_Q_GO;
         S_Q_GO:      state_in = S_Q_WAIT;
         S_Q_WAIT: begin
            if (div_status.done) state_in = S_ROOT_GO;
         end
         S_ROOT_GO:   state_in = S_ROOT_WAIT;
         S_ROOT_WAIT: begin
            if (sqrt_status.done) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath control for each step of the sequence.
   always_comb begin
      block_sum_in   = block_sum_ff;
      block_fill_in  = block_fill_ff;
      blocks_done_in = blocks_done_ff;
      mean_sum_in    = mean_sum_ff;
      mss_in         = mss_ff;
      sample_in      = sample_ff;
      mean_in        = mean_ff;
      rmean_in       = rmean_ff;
      err_in         = err_ff;
      sdone_in       = sdone_ff;
      acc_in         = acc_ff;
      diff_in        = diff_ff;
      prod_in        = prod_ff;
      mult_a         = '0;
      mult_b         = '0;
      div_start      = 1'b0;
      div_num        = '0;
      div_den        = '0;
      sqrt_start     = 1'b0;
      if (req_fire) sample_in = req_q16;
      case (state_ff)
         S_ACC: begin
            // The multiplier squares the deviation from one half in mode one.
            mult_a = 32'(abs_dev);
            mult_b = 32'(abs_dev);
            if (!run_over) begin
               block_sum_in  = block_sum_ff + 32'(term);
               block_fill_in = closes ? 16'd0 : fill_inc;
            end
         end
         S_MEAN_GO: begin
            div_start    = 1'b1;
            div_num      = DIV_NUM_BITS'(mean_num);
            div_den      = DIV_DEN_BITS'(len);
            block_sum_in = '0;
         end
         S_MEAN_WAIT: begin
            if (div_status.done) mean_in = sat16(div_quot);
         end
         S_UPD: begin
            blocks_done_in = blocks_done_ff + 16'd1;
            mean_sum_in    = mean_sum_ff + 32'(mean_ff);
            mult_a         = 32'(mean_ff);
            mult_b         = 32'(mean_ff);
            prod_in        = mult_p;
         end
         S_MSQ: begin
            mss_in  = mss_ff + prod_ff[47:0];
            mult_a  = 32'(blocks_done_ff);
            mult_b  = 32'(len);
            prod_in = mult_p;
         end
         S_RMEAN_GO: begin
            sdone_in  = prod_ff[31:0];
            div_start = 1'b1;
            div_num   = DIV_NUM_BITS'(rmean_num);
            div_den   = DIV_DEN_BITS'(blocks_done_ff);
         end
         S_RMEAN_WAIT: begin
            if (div_status.done) begin
               rmean_in = sat16(div_quot);
               err_in   = '0;
            end
         end
         S_A_LO: begin
            // n times the square sum, low word first.
            mult_a  = mss_ff[31:0];
            mult_b  = 32'(blocks_done_ff);
            prod_in = mult_p;
         end
         S_A_HI: begin
            acc_in  = prod_ff;
            mult_a  = 32'(mss_ff[47:32]);
            mult_b  = 32'(blocks_done_ff);
            prod_in = mult_p;
         end
         S_B: begin
            acc_in  = acc_ff + {prod_ff[31:0], 32'b0};
            mult_a  = mean_sum_ff;
            mult_b  = mean_sum_ff;
            prod_in = mult_p;
         end
         S_DIFF: begin
            diff_in = sub_ab[64] ? (prod_ff - acc_ff) : sub_ab[63:0];
            mult_a  = 32'(blocks_done_ff);
            mult_b  = 32'(blocks_done_ff);
            prod_in = mult_p;
         end
         S_DEN: begin
            // n squared times (n - 1) fits in 48 bits.
            mult_a  = prod_ff[31:0];
            mult_b  = 32'(blocks_done_ff - 16'd1);
            prod_in = mult_p;
         end
         S_Q_GO: begin
            div_start = 1'b1;
            div_num   = diff_ff;
            div_den   = prod_ff[DIV_DEN_BITS-1:0];
         end
         S_ROOT_GO: begin
            sqrt_start = 1'b1;
         end
         S_ROOT_WAIT: begin
            if (sqrt_status.done) err_in = sat16(DIV_NUM_BITS'(sqrt_root));
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Configuration writes.
   always_comb begin
      block_length_in = block_length_ff;
      block_count_in  = block_count_ff;
      mode_in         = mode_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_BLOCK_LENGTH: block_length_in = csr_data;
            CSR_BLOCK_COUNT:  block_count_in  = csr_data;
            CSR_MODE:         mode_in         = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         block_length_ff <= 16'd100;
         block_count_ff  <= 16'd100;
         mode_ff         <= 1'b0;
         block_sum_ff    <= '0;
         block_fill_ff   <= '0;
         blocks_done_ff  <= '0;
         mean_sum_ff     <= '0;
         mss_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         block_length_ff <= block_length_in;
         block_count_ff  <= block_count_in;
         mode_ff         <= mode_in;
         block_sum_ff    <= block_sum_in;
         block_fill_ff   <= block_fill_in;
         blocks_done_ff  <= blocks_done_in;
         mean_sum_ff     <= mean_sum_in;
         mss_ff          <= mss_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      mean_ff   <= mean_in;
      rmean_ff  <= rmean_in;
      err_ff    <= err_in;
      sdone_ff  <= sdone_in;
      acc_ff    <= acc_in;
      diff_ff   <= diff_in;
      prod_ff   <= prod_in;
      if (rsp_load) begin
         rsp_samples_done_ff <= sdone_ff;
         rsp_running_mean_ff <= rmean_ff;
         rsp_std_error_ff    <= err_ff;
         rsp_block_number_ff <= blocks_done_ff;
         rsp_last_block_ff   <= (blocks_done_ff == block_count_ff);
      end
   end

   bae_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quot   (div_quot),
      .status (div_status)
   );

   bae_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .rad    (div_quot),
      .root   (sqrt_root),
      .status (sqrt_status)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_samples_done = rsp_samples_done_ff;
   assign rsp_running_mean = rsp_running_mean_ff;
   assign rsp_std_error    = rsp_std_error_ff;
   assign rsp_block_number = rsp_block_number_ff;
   assign rsp_last_block   = rsp_last_block_ff;

   // A result only appears after the output step of the sequence.
   `BAE_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)
   // The shared units are never restarted in the middle of an operation.
   `BAE_ASSERT_IMP(a_div_free, clock, reset, div_start, !div_status.busy)
   `BAE_ASSERT_IMP(a_sqrt_free, clock, reset, sqrt_start, !sqrt_status.busy)
   // A started division is running in the following cycle.
   `BAE_ASSERT_NXT(a_div_runs, clock, reset, div_start, div_status.busy)
   // The block counter never wraps, so the running mean never divides by zero.
   `BAE_ASSERT_IMP(a_n_nonzero, clock, reset, state_ff == S_MSQ, blocks_done_ff != '0)

endmodule

`default_nettype wire
